/* src/point_in_cylinder_test_defines.svh */
// assertion macros used by the checker file
`ifndef POINT_IN_CYLINDER_TEST_DEFINES_SVH
`define POINT_IN_CYLINDER_TEST_DEFINES_SVH

// implication checked at every clock edge outside reset
`define PIC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("point_in_cylinder_test: implication check failed");

// condition that must hold at every clock edge outside reset
`define PIC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("point_in_cylinder_test: invariant check failed");

`endif

/* src/pic_pkg.sv */
package pic_pkg;

  // coordinate format, signed fixed point
  localparam int COORD_WIDTH = 24;

  // squared quantities, unsigned fixed point
  localparam int SQ_WIDTH = 50;
  localparam logic [SQ_WIDTH-1:0] RADIUS_RESET = 50'd4194304;

  // derived widths of the front end
  localparam int DIFF_W   = COORD_WIDTH + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int DOT_FULL = PROD_W + 2;

  // squaring of the dot product split into halves
  localparam int LO_W = SQ_WIDTH / 2;
  localparam int HI_W = SQ_WIDTH - LO_W;
  localparam int NUM_W = 2 * SQ_WIDTH;

  // clamped |p|^2 keeps two guard bits above the result width
  localparam int PSQ_C_W = SQ_WIDTH + 2;

  // one quotient bit per divider stage
  localparam int DIV_STEPS = SQ_WIDTH;

  // clock edges from the accepting edge to the edge that takes the result
  localparam int LATENCY = DIV_STEPS + 8;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] axis_start_x;
    logic signed [COORD_WIDTH-1:0] axis_start_y;
    logic signed [COORD_WIDTH-1:0] axis_start_z;
    logic signed [COORD_WIDTH-1:0] axis_end_x;
    logic signed [COORD_WIDTH-1:0] axis_end_y;
    logic signed [COORD_WIDTH-1:0] axis_end_z;
    logic [SQ_WIDTH-1:0]           axis_len_sq;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
  } query_t;

  typedef struct packed {
    logic                inside_res;
    logic [SQ_WIDTH-1:0] dist_sq;
  } result_t;

endpackage

/* src/point_in_cylinder_test.sv */
// Point in capped cylinder test. One item is taken at every clock edge where
// start is high and busy is low; busy is only high during reset, so an item
// may enter on every cycle. Each item yields exactly one result, shown on
// result for a single cycle with done high. Results leave in item order
// and cannot be held off: the receiver must take every cycle in which done
// is high. The depth is set mostly by the 50-stage restoring divider that
// forms dot^2 / axis_len_sq, one quotient bit per stage. radius_sq is
// written through cfg_valid/cfg_data (cfg_ready is always high) and must
// only change while no item is in flight.
module point_in_cylinder_test (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  pic_pkg::query_t          query,
  output logic                     done,
  output pic_pkg::result_t         result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [pic_pkg::SQ_WIDTH-1:0] cfg_data
);
  import pic_pkg::*;

  typedef struct packed {
    logic                pass;
    logic                zero;
    logic [PSQ_C_W-1:0]  psq;
    logic [SQ_WIDTH-1:0] den;
    logic [SQ_WIDTH-1:0] rem;
    logic [SQ_WIDTH-1:0] sh;
  } div_stage_t;

  logic accept;
  logic [SQ_WIDTH-1:0] radius_sq;

  // stage 1: differences
  logic v1;
  logic signed [DIFF_W-1:0] d1x, d1y, d1z, p1x, p1y, p1z;
  logic [SQ_WIDTH-1:0] lsq1;

  // stage 2: products
  logic v2;
  logic signed [PROD_W-1:0] m2x, m2y, m2z, s2x, s2y, s2z;
  logic [SQ_WIDTH-1:0] lsq2;

  // stage 3: sums
  logic v3;
  logic signed [DOT_FULL-1:0] dot_sum, psq_sum;
  logic [63:0] dot3, psq3;
  logic [SQ_WIDTH-1:0] lsq3;

  // stage 4: cap test and clamp
  logic v4, pass4, zero4;
  logic [SQ_WIDTH-1:0] dot4, lsq4;
  logic [PSQ_C_W-1:0] psq4;

  // stage 5: partial squares
  logic v5, pass5, zero5;
  logic [2*HI_W-1:0] phh5;
  logic [HI_W+LO_W-1:0] phl5;
  logic [2*LO_W-1:0] pll5;
  logic [PSQ_C_W-1:0] psq5;
  logic [SQ_WIDTH-1:0] lsq5;
  logic [NUM_W-1:0] num;

  // divider stages
  logic       div_vld [DIV_STEPS+1];
  div_stage_t div_q   [DIV_STEPS+1];

  // subtract stage
  logic v7, pass7;
  logic [SQ_WIDTH-1:0] term, dsq7;
  logic [PSQ_C_W-1:0] dsq_raw;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // radius register
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_sq <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radius_sq <= cfg_data;
    end
  end

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      div_vld[0] <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      div_vld[0] <= v5;
    end
  end

  // axis and point vectors relative to the start point
  always_ff @(posedge clk) begin
    d1x  <= DIFF_W'(query.axis_end_x) - DIFF_W'(query.axis_start_x);
    d1y  <= DIFF_W'(query.axis_end_y) - DIFF_W'(query.axis_start_y);
    d1z  <= DIFF_W'(query.axis_end_z) - DIFF_W'(query.axis_start_z);
    p1x  <= DIFF_W'(query.point_x) - DIFF_W'(query.axis_start_x);
    p1y  <= DIFF_W'(query.point_y) - DIFF_W'(query.axis_start_y);
    p1z  <= DIFF_W'(query.point_z) - DIFF_W'(query.axis_start_z);
    lsq1 <= query.axis_len_sq;
  end

  // per-axis products for dot and |p|^2
  always_ff @(posedge clk) begin
    m2x  <= p1x * d1x;
    m2y  <= p1y * d1y;
    m2z  <= p1z * d1z;
    s2x  <= p1x * p1x;
    s2y  <= p1y * p1y;
    s2z  <= p1z * p1z;
    lsq2 <= lsq1;
  end

  // sums, kept modulo 2^64
  assign dot_sum = DOT_FULL'(m2x) + DOT_FULL'(m2y) + DOT_FULL'(m2z);
  assign psq_sum = DOT_FULL'(s2x) + DOT_FULL'(s2y) + DOT_FULL'(s2z);

  always_ff @(posedge clk) begin
    dot3 <= 64'(dot_sum);
    psq3 <= 64'(psq_sum);
    lsq3 <= lsq2;
  end

  // cap test; |p|^2 clamped so that anything large still saturates
  always_ff @(posedge clk) begin
    pass4 <= !dot3[63] && (dot3 <= 64'(lsq3));
    zero4 <= (lsq3 == '0);
    dot4  <= dot3[SQ_WIDTH-1:0];
    lsq4  <= lsq3;
    if (psq3[63:PSQ_C_W-1] != '0) begin
      psq4 <= {1'b1, {(PSQ_C_W-1){1'b0}}};
    end else begin
      psq4 <= {1'b0, psq3[PSQ_C_W-2:0]};
    end
  end

  // dot^2 as three partial products
  always_ff @(posedge clk) begin
    phh5  <= dot4[SQ_WIDTH-1:LO_W] * dot4[SQ_WIDTH-1:LO_W];
    phl5  <= dot4[SQ_WIDTH-1:LO_W] * dot4[LO_W-1:0];
    pll5  <= dot4[LO_W-1:0] * dot4[LO_W-1:0];
    pass5 <= pass4;
    zero5 <= zero4;
    psq5  <= psq4;
    lsq5  <= lsq4;
  end

  assign num = (NUM_W'(phh5) << (2 * LO_W)) + (NUM_W'(phl5) << (LO_W + 1))
             + NUM_W'(pll5);

  // divider entry: upper half is the first partial remainder
  always_ff @(posedge clk) begin
    div_q[0].pass <= pass5;
    div_q[0].zero <= zero5;
    div_q[0].psq  <= psq5;
    div_q[0].den  <= lsq5;
    div_q[0].rem  <= num[NUM_W-1:SQ_WIDTH];
    div_q[0].sh   <= num[SQ_WIDTH-1:0];
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [SQ_WIDTH:0]   trial;
    logic [SQ_WIDTH+1:0] diff;
    logic                ge;

    assign trial = {div_q[k-1].rem, div_q[k-1].sh[SQ_WIDTH-1]};
    assign diff  = {1'b0, trial} - {2'b00, div_q[k-1].den};
    assign ge    = !diff[SQ_WIDTH+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        div_vld[k] <= 1'b0;
      end else begin
        div_vld[k] <= div_vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      div_q[k].pass <= div_q[k-1].pass;
      div_q[k].zero <= div_q[k-1].zero;
      div_q[k].psq  <= div_q[k-1].psq;
      div_q[k].den  <= div_q[k-1].den;
      div_q[k].rem  <= ge ? diff[SQ_WIDTH-1:0] : trial[SQ_WIDTH-1:0];
      div_q[k].sh   <= {div_q[k-1].sh[SQ_WIDTH-2:0], ge};
    end
  end

  // distance: |p|^2 minus projection term, clamped at zero and saturated
  assign term    = div_q[DIV_STEPS].zero ? '0 : div_q[DIV_STEPS].sh;
  assign dsq_raw = (div_q[DIV_STEPS].psq >= PSQ_C_W'(term))
                 ? div_q[DIV_STEPS].psq - PSQ_C_W'(term) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= div_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    pass7 <= div_q[DIV_STEPS].pass;
    if (dsq_raw[PSQ_C_W-1:SQ_WIDTH] != '0) begin
      dsq7 <= '1;
    end else begin
      dsq7 <= dsq_raw[SQ_WIDTH-1:0];
    end
  end

  // radius test and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v7;
    end
  end

  always_ff @(posedge clk) begin
    result.inside_res <= pass7 && (dsq7 <= radius_sq);
    result.dist_sq    <= (pass7 && (dsq7 <= radius_sq)) ? dsq7 : '0;
  end

endmodule

/* src/pic_checker.sv */
`include "point_in_cylinder_test_defines.svh"

module pic_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input pic_pkg::result_t             result,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [pic_pkg::SQ_WIDTH-1:0] cfg_data
);
  import pic_pkg::*;

  logic [SQ_WIDTH-1:0] radius_seen;

  // radius as last written on the port
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_seen <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radius_seen <= cfg_data;
    end
  end

  // both channels always take items once reset has been seen low
  `PIC_ASSERT_IMPL(a_always_ready, !rst, !busy && cfg_ready)

  // every accepted item yields a result at fixed latency
  `PIC_ASSERT_IMPL(a_item_gets_result, $past(start && !busy, LATENCY), done)

  // every result belongs to an item accepted at fixed latency before
  `PIC_ASSERT_IMPL(a_result_has_item, done, $past(start && !busy, LATENCY))

  // an outside result reports zero distance
  `PIC_ASSERT_IMPL(a_outside_zero, done && !result.inside_res, result.dist_sq == '0)

  // an inside result lies within the configured radius
  `PIC_ASSERT_IMPL(a_inside_radius, done && result.inside_res, result.dist_sq <= radius_seen)

endmodule

bind point_in_cylinder_test pic_checker u_pic_checker (.*);
